// ===== sv/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the depacketizer checkers.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by reset
`define RDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("depacketizer check failed");

// next-cycle implication, gated by reset
`define RDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("depacketizer check failed");

`endif

// ===== sv/rdp_pkg.sv =====
// ------------------------------------------------------------------------
// rdp_pkg
// Types and constants shared by the RTP H.264 depacketizer modules.
// ------------------------------------------------------------------------
`default_nettype none

package rdp_pkg;

  // RTP fixed header length in bytes
  localparam int unsigned HEADER_LEN = 12;

  // command queue depth between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // NAL unit constants
  localparam logic [4:0] NAL_TYPE_SINGLE_MAX = 5'h17;
  localparam logic [4:0] NAL_TYPE_FU_A       = 5'h1c;
  localparam logic [7:0] NAL_SPS             = 8'h67;
  localparam logic [7:0] FU_IND_MASK         = 8'he0;

  // packet modes
  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_SINGLE  = 2'd1;
  localparam logic [1:0] MODE_FU      = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_DATA      = 3'd0;
  localparam logic [2:0] KIND_EMPTY_END = 3'd1;
  localparam logic [2:0] KIND_GAP       = 3'd2;
  localparam logic [2:0] KIND_SHORT     = 3'd3;
  localparam logic [2:0] KIND_UNSUP     = 3'd4;

  // command operations (front -> back)
  localparam logic [2:0] CMD_NONE      = 3'd0; // gap report only
  localparam logic [2:0] CMD_DATA      = 3'd1;
  localparam logic [2:0] CMD_START     = 3'd2; // start code + NAL byte
  localparam logic [2:0] CMD_EMPTY_END = 3'd3;
  localparam logic [2:0] CMD_SHORT     = 3'd4;
  localparam logic [2:0] CMD_UNSUP     = 3'd5;

  // start code prefix length plus the NAL byte
  localparam logic [2:0] START_LEN = 3'd5;

  typedef struct packed {
    logic       gap;   // sequence gap result goes first
    logic [2:0] op;
    logic [7:0] data;
    logic       fin;   // frame end on the final result
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/rdp_front.sv =====
// ------------------------------------------------------------------------
// rdp_front
// Tracks packet position, sequence numbers and frame state; turns each
// accepted byte into at most one command word for the back end.
// ------------------------------------------------------------------------
`default_nettype none

module rdp_front import rdp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,        // byte accepted this cycle
  input  wire logic [7:0] in_byte,
  input  wire logic       in_pkt_last,
  output cmd_t            cmd,
  output logic            cmd_push
);

  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  seq_hi_r, seq_hi_nxt;
  logic [15:0] prev_seq_r, prev_seq_nxt;
  logic        prev_ok_r, prev_ok_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  ind_r, ind_nxt;
  logic        fes_r, fes_nxt;
  logic        sps_r, sps_nxt;
  logic        fp_r, fp_nxt;

  logic [15:0] seq;
  logic [7:0]  nal;
  logic        fin;

  // classification and next state
  always_comb begin
    idx_nxt      = idx_r;
    seq_hi_nxt   = seq_hi_r;
    prev_seq_nxt = prev_seq_r;
    prev_ok_nxt  = prev_ok_r;
    mode_nxt     = mode_r;
    ind_nxt      = ind_r;
    fes_nxt      = fes_r;
    sps_nxt      = sps_r;
    fp_nxt       = fp_r;
    cmd          = '{gap: 1'b0, op: CMD_NONE, data: 8'h00, fin: 1'b0};
    seq          = {seq_hi_r, in_byte};
    nal          = (ind_r & FU_IND_MASK) | {3'b000, in_byte[4:0]};
    fin          = 1'b0;

    if (idx_r < 16'(HEADER_LEN)) begin
      // RTP header
      if (idx_r == 16'd2) seq_hi_nxt = in_byte;
      if (idx_r == 16'd3) begin
        cmd.gap      = prev_ok_r && (seq != prev_seq_r + 16'd1);
        prev_seq_nxt = seq;
        prev_ok_nxt  = 1'b1;
      end
      if (in_pkt_last) cmd.op = CMD_SHORT;
    end else if (idx_r == 16'(HEADER_LEN)) begin
      // payload type byte
      if (in_byte[4:0] <= NAL_TYPE_SINGLE_MAX) begin
        mode_nxt = MODE_SINGLE;
        fp_nxt   = sps_r || (in_byte == NAL_SPS);
        if (fp_nxt) begin
          cmd.op   = CMD_START;
          cmd.data = in_byte;
          cmd.fin  = in_pkt_last;
        end
        if (in_pkt_last) begin
          sps_nxt = sps_r | fp_nxt;
          fp_nxt  = 1'b0;
        end
      end else if (in_byte[4:0] == NAL_TYPE_FU_A) begin
        mode_nxt = MODE_FU;
        ind_nxt  = in_byte;
        if (in_pkt_last) cmd.op = CMD_SHORT;
      end else begin
        mode_nxt = MODE_DISCARD;
        cmd.op   = CMD_UNSUP;
      end
    end else if (mode_r == MODE_SINGLE) begin
      if (fp_r) begin
        cmd.op   = CMD_DATA;
        cmd.data = in_byte;
        cmd.fin  = in_pkt_last;
      end
      if (in_pkt_last) begin
        sps_nxt = sps_r | fp_r;
        fp_nxt  = 1'b0;
      end
    end else if (mode_r == MODE_FU) begin
      if (idx_r == 16'(HEADER_LEN + 1)) begin
        // FU header: start / end bits
        fes_nxt = in_byte[6];
        fin     = in_pkt_last && in_byte[6];
        if (in_byte[7]) begin
          fp_nxt = sps_r || (nal == NAL_SPS);
          if (fp_nxt) begin
            cmd.op   = CMD_START;
            cmd.data = nal;
            cmd.fin  = fin;
          end
        end else if (fin && fp_r) begin
          cmd.op  = CMD_EMPTY_END;
          cmd.fin = 1'b1;
        end
      end else begin
        fin = in_pkt_last && fes_r;
        if (fp_r) begin
          cmd.op   = CMD_DATA;
          cmd.data = in_byte;
          cmd.fin  = fin;
        end
      end
      if (fin) begin
        sps_nxt = sps_r | fp_nxt;
        fp_nxt  = 1'b0;
      end
    end

    // packet position
    if (in_pkt_last) begin
      idx_nxt  = 16'd0;
      mode_nxt = MODE_HEADER;
    end else if (idx_r != 16'hffff) begin
      idx_nxt = idx_r + 16'd1;
    end
  end

  assign cmd_push = acc && (cmd.gap || (cmd.op != CMD_NONE));

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      seq_hi_r   <= '0;
      prev_seq_r <= '0;
      prev_ok_r  <= 1'b0;
      mode_r     <= MODE_HEADER;
      ind_r      <= '0;
      fes_r      <= 1'b0;
      sps_r      <= 1'b0;
      fp_r       <= 1'b0;
    end else if (acc) begin
      idx_r      <= idx_nxt;
      seq_hi_r   <= seq_hi_nxt;
      prev_seq_r <= prev_seq_nxt;
      prev_ok_r  <= prev_ok_nxt;
      mode_r     <= mode_nxt;
      ind_r      <= ind_nxt;
      fes_r      <= fes_nxt;
      sps_r      <= sps_nxt;
      fp_r       <= fp_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rdp_cmd_fifo.sv =====
// ------------------------------------------------------------------------
// rdp_cmd_fifo
// Small command queue that decouples the front end from the back end.
// ------------------------------------------------------------------------
`default_nettype none

module rdp_cmd_fifo import rdp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wdata,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      full,
  output logic      empty
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/rdp_back.sv =====
// ------------------------------------------------------------------------
// rdp_back
// Expands each command word into result words, one per cycle while the output
// is not stalled by out_ready, into a registered output stage.
// ------------------------------------------------------------------------
`default_nettype none

module rdp_back import rdp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  cmd_t            head,
  input  wire logic       head_ok,     // queue not empty
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            out_frame_start,
  output logic            out_frame_end,
  output logic            out_last
);

  logic       out_valid_r;
  logic [7:0] byte_r,  byte_nxt;
  logic [2:0] kind_r,  kind_nxt;
  logic       fs_r,    fs_nxt;
  logic       fe_r,    fe_nxt;
  logic       last_r,  last_nxt;
  logic [2:0] step_r,  step_nxt;

  logic       load;
  logic [2:0] total;
  logic [2:0] sub;

  assign load = !out_valid_r || out_ready;

  // result selection for the current step of the head command
  always_comb begin
    byte_nxt = 8'h00;
    kind_nxt = KIND_DATA;
    fs_nxt   = 1'b0;
    fe_nxt   = 1'b0;
    sub      = step_r - 3'(head.gap);
    unique case (head.op)
      CMD_NONE:  total = 3'(head.gap);
      CMD_START: total = START_LEN + 3'(head.gap);
      default:   total = 3'd1 + 3'(head.gap);
    endcase

    if (head.gap && (step_r == 3'd0)) begin
      kind_nxt = KIND_GAP;
    end else begin
      unique case (head.op)
        CMD_START: begin
          fs_nxt   = (sub == 3'd0);
          byte_nxt = (sub == 3'd3) ? 8'h01 : 8'h00;
          if (sub == 3'd4) begin
            byte_nxt = head.data;
            fe_nxt   = head.fin;
          end
        end
        CMD_DATA: begin
          byte_nxt = head.data;
          fe_nxt   = head.fin;
        end
        CMD_EMPTY_END: begin
          kind_nxt = KIND_EMPTY_END;
          fe_nxt   = 1'b1;
        end
        CMD_SHORT: kind_nxt = KIND_SHORT;
        CMD_UNSUP: kind_nxt = KIND_UNSUP;
        default:   kind_nxt = KIND_GAP;
      endcase
    end

    last_nxt = (step_r + 3'd1 == total);
    pop      = load && head_ok && last_nxt;
    step_nxt = step_r;
    if (load && head_ok) step_nxt = last_nxt ? 3'd0 : step_r + 3'd1;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      step_r <= step_nxt;
      if (load) out_valid_r <= head_ok;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load && head_ok) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      fs_r   <= fs_nxt;
      fe_r   <= fe_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_kind        = kind_r;
  assign out_frame_start = fs_r;
  assign out_frame_end   = fe_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// ===== sv/rtp_h264_depacketizer_unit.sv =====
// Path: command words are queued; result words are registered from the queue head.
// Throughput: one input byte per cycle while the queue is not full; one result
// word per cycle while out_ready allows; a frame start becomes five result words
// (start code + NAL), soaked up by the four-entry front-to-back command queue.
// Reset: rst_n synchronous, active low; clears packet position, sequence
// tracking, frame state, the queue and the output stage.
// ------------------------------------------------------------------------
// rtp_h264_depacketizer_unit
// RTP H.264 depacketizer: single NAL and FU-A packets to start-code stream.
// ------------------------------------------------------------------------
`default_nettype none

module rtp_h264_depacketizer_unit import rdp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_pkt_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            out_frame_start,
  output logic            out_frame_end,
  output logic            out_last
);

  cmd_t cmd, head;
  logic cmd_push, pop, full, empty, acc;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  rdp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_byte     (in_byte),
    .in_pkt_last (in_pkt_last),
    .cmd         (cmd),
    .cmd_push    (cmd_push)
  );

  rdp_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd),
    .pop   (pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  rdp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_ok         (!empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== sv/rdp_checker.sv =====
// ------------------------------------------------------------------------
// rdp_checker
// Port-level checks on the depacketizer result channel.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rdp_checker import rdp_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_kind,
  input wire logic       out_frame_start,
  input wire logic       out_frame_end
);

  // stalled word holds
  `RDP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_kind))
  // flag words carry no byte
  `RDP_ASSERT_NOW(a_flag_zero, clk, rst_n, out_valid && (out_kind != KIND_DATA), out_byte == 8'h00)
  // frame start is the first zero of a start code
  `RDP_ASSERT_NOW(a_fs_word, clk, rst_n, out_valid && out_frame_start, (out_kind == KIND_DATA) && (out_byte == 8'h00) && !out_frame_end)
  // an empty end always closes the frame
  `RDP_ASSERT_NOW(a_empty_end, clk, rst_n, out_valid && (out_kind == KIND_EMPTY_END), out_frame_end)

endmodule

bind rtp_h264_depacketizer_unit rdp_checker u_rdp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_kind        (out_kind),
  .out_frame_start (out_frame_start),
  .out_frame_end   (out_frame_end)
);

`default_nettype wire

// ===== tb/sv/rtp_h264_depacketizer_checker.sv =====
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// rtp_h264_depacketizer_checker
// Watches both channels of the depacketizer, predicts the start-code
// stream from every accepted input word, and compares each result word.
// ------------------------------------------------------------------------

module rtp_h264_depacketizer_checker import rdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_pkt_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [2:0] out_kind,
  input  logic       out_frame_start,
  input  logic       out_frame_end,
  input  logic       out_last,
  output int         mismatches,
  output int         pending_words,
  output int         bytes_seen,
  output int         words_seen,
  output int         starts_seen,
  output int         gaps_seen,
  output int         shorts_seen,
  output int         unsup_seen,
  output int         empty_ends_seen
);

  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       fs;
    logic       fe;
    logic       lst;
  } stream_word_t;

  // result words still owed by the block, oldest first
  stream_word_t stream_words_due[$];
  stream_word_t want;

  // depacketizer state as the block should hold it
  logic [15:0] pos;           // byte position in packet, saturating
  logic [7:0]  seq_hi;
  logic [15:0] last_seq;
  logic        last_seq_ok;
  logic [1:0]  pkt_mode;
  logic [7:0]  fu_indicator;
  logic        fu_end_bit;
  logic        sps_done;      // an SPS frame has completed
  logic        frame_open;    // a passing frame is open

  task automatic report_mismatch(input string what, input int got, input int want_v);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want_v);
  endtask

  function automatic void push_word(logic [7:0] d, logic [2:0] k, logic fs, logic fe);
    stream_word_t w;
    w.data = d;
    w.kind = k;
    w.fs   = fs;
    w.fe   = fe;
    w.lst  = 1'b0;
    stream_words_due.push_back(w);
  endfunction

  // 00 00 00 01 then the NAL byte
  function automatic void push_start(logic [7:0] nal, logic fin);
    push_word(8'h00, KIND_DATA, 1'b1, 1'b0);
    push_word(8'h00, KIND_DATA, 1'b0, 1'b0);
    push_word(8'h00, KIND_DATA, 1'b0, 1'b0);
    push_word(8'h01, KIND_DATA, 1'b0, 1'b0);
    push_word(nal,   KIND_DATA, 1'b0, fin);
  endfunction

  function automatic void close_frame();
    if (frame_open)
      sps_done = 1'b1;
    frame_open = 1'b0;
  endfunction

  // expected result words for one input byte
  function automatic void predict_stream(logic [7:0] b, logic lastp);
    int           n_prior;
    logic [15:0]  seq;
    logic [7:0]   nal;
    logic         fin;
    stream_word_t w;
    n_prior = stream_words_due.size();
    if (pos < HEADER_LEN) begin
      if (pos == 2)
        seq_hi = b;
      if (pos == 3) begin
        seq = {seq_hi, b};
        if (last_seq_ok && seq != last_seq + 16'd1)
          push_word(8'h00, KIND_GAP, 1'b0, 1'b0);
        last_seq    = seq;
        last_seq_ok = 1'b1;
      end
      if (lastp)
        push_word(8'h00, KIND_SHORT, 1'b0, 1'b0);
    end else if (pos == HEADER_LEN) begin
      if (b[4:0] <= NAL_TYPE_SINGLE_MAX) begin
        pkt_mode   = MODE_SINGLE;
        frame_open = sps_done || b == NAL_SPS;
        if (frame_open)
          push_start(b, lastp);
        if (lastp)
          close_frame();
      end else if (b[4:0] == NAL_TYPE_FU_A) begin
        pkt_mode     = MODE_FU;
        fu_indicator = b;
        if (lastp)
          push_word(8'h00, KIND_SHORT, 1'b0, 1'b0);
      end else begin
        pkt_mode = MODE_DISCARD;
        push_word(8'h00, KIND_UNSUP, 1'b0, 1'b0);
      end
    end else if (pkt_mode == MODE_SINGLE) begin
      if (frame_open)
        push_word(b, KIND_DATA, 1'b0, lastp);
      if (lastp)
        close_frame();
    end else if (pkt_mode == MODE_FU) begin
      if (pos == HEADER_LEN + 1) begin
        // FU header: start bit rebuilds the NAL byte, end bit closes later
        fu_end_bit = b[6];
        fin        = lastp && fu_end_bit;
        if (b[7]) begin
          nal        = (fu_indicator & FU_IND_MASK) | {3'b000, b[4:0]};
          frame_open = sps_done || nal == NAL_SPS;
          if (frame_open)
            push_start(nal, fin);
        end else if (fin && frame_open) begin
          push_word(8'h00, KIND_EMPTY_END, 1'b0, 1'b1);
        end
        if (fin)
          close_frame();
      end else begin
        fin = lastp && fu_end_bit;
        if (frame_open)
          push_word(b, KIND_DATA, 1'b0, fin);
        if (fin)
          close_frame();
      end
    end
    // mark the final word of this byte
    if (stream_words_due.size() > n_prior) begin
      w = stream_words_due.pop_back();
      w.lst = 1'b1;
      stream_words_due.push_back(w);
    end
    if (lastp) begin
      pos      = 16'd0;
      pkt_mode = MODE_HEADER;
    end else if (pos != 16'hffff) begin
      pos = pos + 16'd1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pos             = 16'd0;
      seq_hi          = 8'h00;
      last_seq        = 16'd0;
      last_seq_ok     = 1'b0;
      pkt_mode        = MODE_HEADER;
      fu_indicator    = 8'h00;
      fu_end_bit      = 1'b0;
      sps_done        = 1'b0;
      frame_open      = 1'b0;
      stream_words_due.delete();
      mismatches      = 0;
      bytes_seen      = 0;
      words_seen      = 0;
      starts_seen     = 0;
      gaps_seen       = 0;
      shorts_seen     = 0;
      unsup_seen      = 0;
      empty_ends_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_seen++;
        predict_stream(in_byte, in_pkt_last);
      end
      if (out_valid && out_ready) begin
        words_seen++;
        if (out_frame_start)
          starts_seen++;
        case (out_kind)
          KIND_GAP:       gaps_seen++;
          KIND_SHORT:     shorts_seen++;
          KIND_UNSUP:     unsup_seen++;
          KIND_EMPTY_END: empty_ends_seen++;
          default: ;
        endcase
        if (stream_words_due.size() == 0) begin
          report_mismatch("result word with nothing pending", out_byte, 0);
        end else begin
          want = stream_words_due.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", out_byte, want.data);
          if (out_kind !== want.kind)
            report_mismatch("out_kind", out_kind, want.kind);
          if (out_frame_start !== want.fs)
            report_mismatch("out_frame_start", out_frame_start, want.fs);
          if (out_frame_end !== want.fe)
            report_mismatch("out_frame_end", out_frame_end, want.fe);
          if (out_last !== want.lst)
            report_mismatch("out_last", out_last, want.lst);
        end
      end
    end
    pending_words = stream_words_due.size();
  end

endmodule

// ===== tb/sv/rtp_h264_depacketizer_unit_tb.sv =====
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// rtp_h264_depacketizer_unit_tb
// Feeds RTP packets byte by byte into the depacketizer: directed packets
// for each corner of the protocol, then random packet streams under three
// flow-control mixes. The checker predicts and compares every result word.
// ------------------------------------------------------------------------

module rtp_h264_depacketizer_unit_tb;
  import rdp_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 16;
  localparam int PHASE_BYTES  = 20;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte     = 8'h00;
  logic       in_pkt_last = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       out_frame_start;
  logic       out_frame_end;
  logic       out_last;

  int mismatches, pending_words, bytes_seen, words_seen, starts_seen;
  int gaps_seen, shorts_seen, unsup_seen, empty_ends_seen;

  int          send_idle_pct = 18;
  int          recv_idle_pct = 46;
  int          cycle_count   = 0;
  int          bytes_sent    = 0;
  int          packets_sent  = 0;
  logic [15:0] seq_num       = 16'd0;
  logic [7:0]  pkt_bytes[$];

  rtp_h264_depacketizer_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_pkt_last     (in_pkt_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

  rtp_h264_depacketizer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_pkt_last     (in_pkt_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .pending_words   (pending_words),
    .bytes_seen      (bytes_seen),
    .words_seen      (words_seen),
    .starts_seen     (starts_seen),
    .gaps_seen       (gaps_seen),
    .shorts_seen     (shorts_seen),
    .unsup_seen      (unsup_seen),
    .empty_ends_seen (empty_ends_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words still pending", cycle_count,
               pending_words);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one input word, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic lastp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    in_pkt_last <= lastp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
    pkt_bytes.delete();
  endtask

  // hold off the sender until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // first count bytes of an RTP header carrying seq
  task automatic header_bytes(input logic [15:0] seq, input int count);
    seq_num = seq;
    pkt_bytes.delete();
    for (int i = 0; i < count; i++) begin
      if (i == 2)
        pkt_bytes.push_back(seq[15:8]);
      else if (i == 3)
        pkt_bytes.push_back(seq[7:0]);
      else
        pkt_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++)
      pkt_bytes.push_back(8'($urandom));
  endtask

  // mostly consecutive, sometimes a jump or a run up to the wrap
  function automatic logic [15:0] step_seq();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return 16'($urandom);
    else if (r < 11)
      return 16'hfffe;
    return seq_num + 16'd1;
  endfunction

  function automatic int payload_len();
    if ($urandom_range(99) < 8)
      return $urandom_range(12, 24);
    return $urandom_range(0, 5);
  endfunction

  task automatic fu_fragment(input logic [7:0] ind, input logic s, input logic e,
                             input logic [4:0] ftype);
    header_bytes(step_seq(), HEADER_LEN);
    pkt_bytes.push_back(ind);
    pkt_bytes.push_back({s, e, 1'($urandom_range(1)), ftype});
    add_random(payload_len());
    send_packet();
  endtask

  task automatic random_packet();
    int         r;
    int         shape;
    logic [7:0] ind;
    logic [4:0] ftype;
    logic [4:0] utype;
    r = $urandom_range(99);
    if (r < 35) begin
      // single NAL, SPS now and then
      header_bytes(step_seq(), HEADER_LEN);
      if ($urandom_range(99) < 15)
        pkt_bytes.push_back(NAL_SPS);
      else
        pkt_bytes.push_back({3'($urandom_range(7)), 5'($urandom_range(23))});
      add_random(payload_len());
      send_packet();
    end else if (r < 72) begin
      // FU-A fragment run, sometimes missing its start or its end
      ind   = {3'($urandom_range(7)), NAL_TYPE_FU_A};
      ftype = 5'($urandom_range(31));
      if ($urandom_range(99) < 20) begin
        ind   = NAL_SPS & FU_IND_MASK | {3'b000, NAL_TYPE_FU_A};
        ftype = NAL_SPS[4:0];
      end
      shape = $urandom_range(99);
      if (shape < 10) begin
        fu_fragment(ind, 1'b1, 1'b1, ftype);
      end else begin
        if (shape >= 22)
          fu_fragment(ind, 1'b1, 1'b0, ftype);
        repeat ($urandom_range(2)) fu_fragment(ind, 1'b0, 1'b0, ftype);
        if (shape < 22 || shape >= 34)
          fu_fragment(ind, 1'b0, 1'b1, ftype);
      end
    end else if (r < 82) begin
      // unsupported packing type
      utype = 5'($urandom_range(24, 31));
      if (utype == NAL_TYPE_FU_A)
        utype = 5'd31;
      header_bytes(step_seq(), HEADER_LEN);
      pkt_bytes.push_back({3'($urandom_range(7)), utype});
      add_random(payload_len());
      send_packet();
    end else if (r < 91) begin
      // short: cut inside the header or right after the FU indicator
      if ($urandom_range(1)) begin
        header_bytes(step_seq(), $urandom_range(1, HEADER_LEN));
      end else begin
        header_bytes(step_seq(), HEADER_LEN);
        pkt_bytes.push_back({3'($urandom_range(7)), NAL_TYPE_FU_A});
      end
      send_packet();
    end else begin
      // noise
      pkt_bytes.delete();
      add_random($urandom_range(1, 24));
      send_packet();
    end
  endtask

  task automatic random_phase(input int byte_target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_target)
      random_packet();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // header cut before the sequence number
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hff);
    send_packet();
    // header cut after the sequence number: number is still recorded
    header_bytes(16'hfffe, 5);
    send_packet();
    // non-SPS frame before any SPS is dropped
    header_bytes(16'hffff, HEADER_LEN);
    pkt_bytes.push_back(8'h65);
    add_random(3);
    send_packet();
    // FU-A start rebuilding SPS passes; sequence wraps without a gap
    header_bytes(16'h0000, HEADER_LEN);
    pkt_bytes.push_back(8'h7c);
    pkt_bytes.push_back(8'h87);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hff);
    send_packet();
    // a non-passing frame voids the open SPS frame
    header_bytes(16'd1, HEADER_LEN);
    pkt_bytes.push_back(8'h65);
    add_random(2);
    send_packet();
    // single NAL SPS completes: frames pass from here on
    header_bytes(16'd2, HEADER_LEN);
    pkt_bytes.push_back(NAL_SPS);
    pkt_bytes.push_back(8'hff);
    send_packet();
    // single NAL ending on its NAL byte
    header_bytes(16'd3, HEADER_LEN);
    pkt_bytes.push_back(8'h41);
    send_packet();
    // NAL type zero with extreme payload bytes
    header_bytes(16'd4, HEADER_LEN);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hff);
    pkt_bytes.push_back(8'h00);
    send_packet();
    // FU-A start, middle, and an end fragment with no payload
    header_bytes(16'd5, HEADER_LEN);
    pkt_bytes.push_back(8'h5c);
    pkt_bytes.push_back(8'h81);
    add_random(2);
    send_packet();
    header_bytes(16'd6, HEADER_LEN);
    pkt_bytes.push_back(8'h5c);
    pkt_bytes.push_back(8'h01);
    add_random(1);
    send_packet();
    header_bytes(16'd7, HEADER_LEN);
    pkt_bytes.push_back(8'h5c);
    pkt_bytes.push_back(8'h41);
    send_packet();
    // end fragment and continuation with no frame open are ignored
    header_bytes(16'd8, HEADER_LEN);
    pkt_bytes.push_back(8'h5c);
    pkt_bytes.push_back(8'h41);
    send_packet();
    header_bytes(16'd9, HEADER_LEN);
    pkt_bytes.push_back(8'hfc);
    pkt_bytes.push_back(8'h05);
    add_random(2);
    send_packet();
    // start and end bits in one fragment
    header_bytes(16'd10, HEADER_LEN);
    pkt_bytes.push_back(8'h3c);
    pkt_bytes.push_back(8'hc5);
    pkt_bytes.push_back(8'haa);
    send_packet();
    // FU-A packet ending on its indicator
    header_bytes(16'd11, HEADER_LEN);
    pkt_bytes.push_back(8'h1c);
    send_packet();
    // open FU-A frame, then a new single NAL frame start voids it
    header_bytes(16'd12, HEADER_LEN);
    pkt_bytes.push_back(8'h7c);
    pkt_bytes.push_back(8'h85);
    add_random(1);
    send_packet();
    header_bytes(16'd13, HEADER_LEN);
    pkt_bytes.push_back(8'h21);
    add_random(1);
    send_packet();
    // sequence gap with an unsupported type, then more unsupported types
    header_bytes(16'd20, HEADER_LEN);
    pkt_bytes.push_back(8'h18);
    add_random(2);
    send_packet();
    header_bytes(16'd21, HEADER_LEN);
    pkt_bytes.push_back(8'hff);
    add_random(1);
    send_packet();
    header_bytes(16'd22, HEADER_LEN);
    pkt_bytes.push_back(8'h1d);
    send_packet();
    // header-only packet, then gap and short on the same byte
    header_bytes(16'd23, HEADER_LEN);
    send_packet();
    header_bytes(16'h8000, 4);
    send_packet();

    random_phase(PHASE_BYTES);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 18;
    random_phase(PHASE_BYTES);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_BYTES);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input bytes in %0d packets, %0d result words, %0d frame starts.",
             bytes_seen, packets_sent, words_seen, starts_seen);
    $display("Flag words: %0d sequence gap, %0d short, %0d unsupported, %0d empty end.",
             gaps_seen, shorts_seen, unsup_seen, empty_ends_seen);
    if (mismatches == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, pending_words);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rdp_pkg.sv
sv/rdp_front.sv
sv/rdp_cmd_fifo.sv
sv/rdp_back.sv
sv/rtp_h264_depacketizer_unit.sv
sv/rdp_checker.sv
tb/sv/rtp_h264_depacketizer_checker.sv
tb/sv/rtp_h264_depacketizer_unit_tb.sv
